// ===== design/ecfm_pkg.sv =====
`default_nettype none
package ecfm_pkg;
	localparam int unsigned WindowDef = 5;
	localparam int unsigned FractionBitsDef = 8;
	localparam int unsigned MaxHz = 20000;
	localparam int unsigned FreqW = 23;
	localparam int unsigned RegIdxW = 3;

	localparam logic [1:0] CMD_EDGE = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	localparam logic [RegIdxW-1:0] REG_MODE = 3'd0;
	localparam logic [RegIdxW-1:0] REG_RES = 3'd1;
	localparam logic [RegIdxW-1:0] REG_MINP = 3'd2;
	localparam logic [RegIdxW-1:0] REG_MAXP = 3'd3;
	localparam logic [RegIdxW-1:0] REG_MINPULSE = 3'd4;
	localparam logic [RegIdxW-1:0] REG_TIMEOUT = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SORT,
		ST_DIV,
		ST_DONE,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;       // latch input word, run edge/tick/read logic
		logic div_start;
		logic finish;     // compute result word
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_sort;  // item needs median + division
		logic has_result;
		logic sort_done;
		logic div_done;
	} sts_t;
endpackage
`default_nettype wire

// ===== design/ecfm_if.sv =====
`default_nettype none
interface ecfm_in_if;
	logic valid;
	logic ready;
	logic [1:0] command;
	logic [31:0] timestamp;
	logic rising;
	modport source (output valid, command, timestamp, rising, input ready);
	modport sink (input valid, command, timestamp, rising, output ready);
endinterface

interface ecfm_out_if;
	logic valid;
	logic ready;
	logic [22:0] frequency_q8;
	logic timed_out;
	modport source (output valid, frequency_q8, timed_out, input ready);
	modport sink (input valid, frequency_q8, timed_out, output ready);
endinterface

interface ecfm_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/ecfm_ctrl.sv =====
`default_nettype none
module ecfm_ctrl
	import ecfm_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	output logic in_ready,
	output logic out_valid,
	input  wire  out_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// idle: take; sort/div run only when the item needs a median
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SORT;
			end
			ST_SORT: begin
				if (!sts.need_sort) state_d = ST_DONE;
				else if (sts.sort_done) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = sts.has_result ? ST_OUT : ST_IDLE;
			end
			ST_OUT: begin
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			ST_SORT: begin
				if (sts.need_sort && sts.sort_done) cmd.div_start = 1'b1;
			end
			ST_DIV: ;
			ST_DONE: cmd.finish = 1'b1;
			ST_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== design/ecfm_dp.sv =====
`default_nettype none
module ecfm_dp
	import ecfm_pkg::*;
#(
	parameter int unsigned WINDOW = WindowDef,
	parameter int unsigned FRACTION_BITS = FractionBitsDef
) (
	input  wire  clk,
	input  wire  arst_n,
	input  cmd_t cmd,
	output sts_t sts,
	input  wire [1:0] command,
	input  wire [31:0] timestamp,
	input  wire  rising,
	input  wire  cfg_we,
	input  wire [RegIdxW-1:0] cfg_index,
	input  wire [31:0] cfg_data,
	output logic [FreqW-1:0] frequency_q8,
	output logic timed_out
);
	localparam int unsigned IW = $clog2(WINDOW + 1);
	localparam int unsigned NW = 32 + FRACTION_BITS;
	localparam int unsigned CW = $clog2(NW + 1);
	localparam logic [NW-1:0] CAP = NW'(MaxHz) << FRACTION_BITS;

	logic mode_q;
	logic [31:0] res_q, minp_q, maxp_q, minpulse_q;
	logic [15:0] tmo_q;
	logic [31:0] win_q [WINDOW];
	logic [IW-1:0] widx_q, wcnt_q;
	logic [31:0] lrise_q;
	logic rvalid_q;
	logic [31:0] ptime_q [2];
	logic prise_q [2];
	logic [1:0] pfill_q;
	logic [FreqW-1:0] held_q;
	logic [15:0] ms_q;
	logic read_med_q;   // mode 0 read: result comes from division
	logic upd_held_q;   // mode 1 push: division updates held value
	logic has_res_q, need_q;
	logic [IW-1:0] pos_q;
	logic [31:0] med_q;
	logic [IW-1:0] sc_q;   // candidate index being ranked
	logic [NW-1:0] num_q, quo_q;
	logic [31:0] rem_q;
	logic [CW-1:0] dcnt_q;
	logic div_busy_q, div_done_q, sort_done_q, sort_busy_q;

	// push helpers
	logic [IW-1:0] widx_use, widx_nxt;
	always_comb begin
		widx_use = (widx_q >= IW'(WINDOW)) ? '0 : widx_q;
		widx_nxt = (widx_use == IW'(WINDOW - 1)) ? '0 : widx_use + 1'b1;
	end

	wire [31:0] pa = timestamp - lrise_q;
	wire [31:0] hi_w = ptime_q[1] - ptime_q[0];
	wire [31:0] lo_w = timestamp - ptime_q[1];
	wire [31:0] pb = timestamp - ptime_q[0];
	wire pat_ok = pfill_q == 2'd2 && prise_q[0] && !prise_q[1] && rising &&
		hi_w >= minpulse_q && lo_w >= minpulse_q && pb != 0 && pb >= minp_q;
	wire [IW-1:0] cnt_b = (wcnt_q < IW'(WINDOW)) ? wcnt_q + 1'b1 : wcnt_q;

	// rank select: candidate c is at sorted position pos when
	// #less < pos+1 and #less + #equal > pos, with ties broken by index
	logic [IW-1:0] nless, neq;
	logic is_pick;
	always_comb begin
		nless = '0;
		neq = '0;
		for (int i = 0; i < WINDOW; i++) begin
			if (IW'(i) < wcnt_q) begin
				if (win_q[i] < win_q[sc_q]) nless = nless + 1'b1;
				else if (win_q[i] == win_q[sc_q]) neq = neq + 1'b1;
			end
		end
		is_pick = nless <= pos_q && (nless + neq) > pos_q;
	end

	// restoring division step
	wire [32:0] rem_sh = {rem_q, num_q[NW-1]};
	wire rem_ge = rem_sh >= {1'b0, med_q};
	wire [32:0] rem_sub = rem_sh - {1'b0, med_q};
	wire [NW-1:0] q_sat = (quo_q > CAP) ? CAP : quo_q;
	wire [FreqW-1:0] q_out = q_sat[FreqW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			res_q <= 32'd80000000;
			minp_q <= 32'd4000;
			maxp_q <= 32'd16000000;
			minpulse_q <= 32'd8000;
			tmo_q <= 16'd500;
			widx_q <= '0;
			wcnt_q <= '0;
			lrise_q <= '0;
			rvalid_q <= 1'b0;
			pfill_q <= '0;
			held_q <= '0;
			ms_q <= '0;
			read_med_q <= 1'b0;
			upd_held_q <= 1'b0;
			has_res_q <= 1'b0;
			need_q <= 1'b0;
			sort_busy_q <= 1'b0;
			sort_done_q <= 1'b0;
			div_busy_q <= 1'b0;
			div_done_q <= 1'b0;
			pos_q <= '0;
			med_q <= '0;
			sc_q <= '0;
			num_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
			dcnt_q <= '0;
			frequency_q8 <= '0;
			timed_out <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MODE: begin
						mode_q <= cfg_data[0];
						widx_q <= '0;
						wcnt_q <= '0;
						lrise_q <= '0;
						rvalid_q <= 1'b0;
						pfill_q <= '0;
						held_q <= '0;
						ms_q <= '0;
					end
					REG_RES: res_q <= cfg_data;
					REG_MINP: minp_q <= cfg_data;
					REG_MAXP: maxp_q <= cfg_data;
					REG_MINPULSE: minpulse_q <= cfg_data;
					REG_TIMEOUT: tmo_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.take) begin
				has_res_q <= 1'b0;
				need_q <= 1'b0;
				read_med_q <= 1'b0;
				upd_held_q <= 1'b0;
				sort_done_q <= 1'b0;
				div_done_q <= 1'b0;
				sc_q <= '0;
				timed_out <= 1'b0;
				unique case (command)
					CMD_EDGE: begin
						if (!mode_q) begin
							if (rising) begin
								if (!rvalid_q || pa >= minp_q) begin
									lrise_q <= timestamp;
									rvalid_q <= 1'b1;
								end
								if (rvalid_q && pa >= minp_q && pa <= maxp_q) begin
									win_q[widx_use] <= pa;
									widx_q <= widx_nxt;
									if (wcnt_q < IW'(WINDOW)) wcnt_q <= wcnt_q + 1'b1;
									ms_q <= '0;
								end
							end
						end else begin
							ms_q <= '0;
							if (pfill_q < 2'd2) begin
								ptime_q[pfill_q[0]] <= timestamp;
								prise_q[pfill_q[0]] <= rising;
								pfill_q <= pfill_q + 1'b1;
							end else begin
								ptime_q[0] <= ptime_q[1];
								prise_q[0] <= prise_q[1];
								ptime_q[1] <= timestamp;
								prise_q[1] <= rising;
								if (pat_ok) begin
									win_q[widx_use] <= pb;
									widx_q <= widx_nxt;
									wcnt_q <= cnt_b;
									need_q <= 1'b1;
									upd_held_q <= 1'b1;
									sort_busy_q <= 1'b1;
									pos_q <= cnt_b - 1'b1 - (cnt_b >> 1);
								end
							end
						end
					end
					CMD_TICK: if (ms_q != 16'hFFFF) ms_q <= ms_q + 1'b1;
					CMD_READ: begin
						has_res_q <= 1'b1;
						if (ms_q > tmo_q) begin
							timed_out <= 1'b1;
							frequency_q8 <= '0;
							if (wcnt_q != 0 || held_q != 0) begin
								widx_q <= '0;
								wcnt_q <= '0;
								lrise_q <= '0;
								rvalid_q <= 1'b0;
								pfill_q <= '0;
								held_q <= '0;
								ms_q <= '0;
							end
						end else if (res_q == 0) begin
							frequency_q8 <= held_q;
						end else if (!mode_q) begin
							frequency_q8 <= '0;
							if (wcnt_q != 0) begin
								need_q <= 1'b1;
								read_med_q <= 1'b1;
								sort_busy_q <= 1'b1;
								pos_q <= wcnt_q >> 1;
							end
						end else begin
							frequency_q8 <= held_q;
							pfill_q <= '0;
						end
					end
					default: ;
				endcase
			end
			// median search, one candidate per cycle
			if (sort_busy_q) begin
				if (is_pick) begin
					med_q <= win_q[sc_q];
					sort_busy_q <= 1'b0;
					sort_done_q <= 1'b1;
				end else begin
					sc_q <= sc_q + 1'b1;
				end
			end
			if (cmd.div_start) begin
				sort_done_q <= 1'b0;
				if (med_q == 0) begin
					quo_q <= '0;
					div_done_q <= 1'b1;
				end else begin
					num_q <= NW'(res_q) << FRACTION_BITS;
					rem_q <= '0;
					quo_q <= '0;
					dcnt_q <= CW'(NW);
					div_busy_q <= 1'b1;
				end
			end
			if (div_busy_q) begin
				num_q <= num_q << 1;
				rem_q <= rem_ge ? rem_sub[31:0] : rem_sh[31:0];
				quo_q <= {quo_q[NW-2:0], rem_ge};
				dcnt_q <= dcnt_q - 1'b1;
				if (dcnt_q == CW'(1)) begin
					div_busy_q <= 1'b0;
					div_done_q <= 1'b1;
				end
			end
			if (cmd.finish && need_q) begin
				if (read_med_q) frequency_q8 <= (med_q == 0) ? held_q : q_out;
				if (upd_held_q) held_q <= (med_q == 0) ? '0 : q_out;
			end
		end
	end

	always_comb begin
		sts.need_sort = need_q;
		sts.has_result = has_res_q;
		sts.sort_done = sort_done_q;
		sts.div_done = div_done_q;
	end
endmodule
`default_nettype wire

// ===== design/edge_capture_frequency_meter_unit.sv =====
`default_nettype none
// channel  dir  handshake      word
// in       in   valid/ready    command, timestamp, rising
// out      out  valid/ready    frequency_q8, timed_out
// cfg      in   valid/ready    index, data
// one item at a time: take, then, for a median read or a mode 1 edge that
// updates the median, median search and the restoring divider, then finish,
// then the result word for a read.
// reset sets registers and state to defaults; the window and the pattern edge buffer hold no reset value.
// out stall holds the block; config is always ready.
module edge_capture_frequency_meter_unit
	import ecfm_pkg::*;
#(
	parameter int unsigned WINDOW = WindowDef,
	parameter int unsigned FRACTION_BITS = FractionBitsDef
) (
	input  wire clk,
	input  wire arst_n,
	ecfm_in_if.sink in,
	ecfm_out_if.source out,
	ecfm_cfg_if.sink cfg
);
	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	ecfm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in.valid), .in_ready(in.ready),
		.out_valid(out.valid), .out_ready(out.ready),
		.sts(sts), .cmd(cmd)
	);

	ecfm_dp #(.WINDOW(WINDOW), .FRACTION_BITS(FRACTION_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.command(in.command), .timestamp(in.timestamp), .rising(in.rising),
		.cfg_we(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
		.frequency_q8(out.frequency_q8), .timed_out(out.timed_out)
	);
endmodule
`default_nettype wire

// ===== tb/ecfm_checker.sv =====
`timescale 1ns / 100ps
module ecfm_checker
	import ecfm_pkg::*;
(
	input  wire clk,
	input  wire arst_n,
	ecfm_in_if in_ch,
	ecfm_out_if out_ch,
	ecfm_cfg_if cfg_ch,
	output int errors,
	output int pending
);
	typedef struct {
		logic [FreqW-1:0] freq;
		logic timed_out;
	} reading_t;

	reading_t readings_due[$];

	logic mode_r;
	logic [31:0] resolution, min_per, max_per, min_pul;
	logic [15:0] timeout_r;

	logic [31:0] win [WindowDef];
	int unsigned win_idx, win_cnt;
	logic [31:0] ref_rise;
	logic ref_ok;
	logic [31:0] pat_ts [2];
	logic pat_rise [2];
	int unsigned pat_fill;
	logic [FreqW-1:0] held;
	logic [15:0] ms_idle;

	assign pending = readings_due.size();

	function automatic void clear_meter();
		win_idx = 0;
		win_cnt = 0;
		ref_rise = '0;
		ref_ok = 1'b0;
		pat_fill = 0;
		held = '0;
		ms_idle = '0;
	endfunction

	function automatic void store_period(logic [31:0] p);
		win[win_idx] = p;
		win_idx = (win_idx + 1) % WindowDef;
		if (win_cnt < WindowDef) win_cnt++;
	endfunction

	function automatic logic [31:0] period_rank(int unsigned pos);
		logic [31:0] t [WindowDef];
		logic [31:0] k;
		int j;
		for (int i = 0; i < win_cnt; i++) t[i] = win[i];
		for (int i = 1; i < win_cnt; i++) begin
			k = t[i];
			j = i;
			while (j > 0 && t[j-1] > k) begin
				t[j] = t[j-1];
				j--;
			end
			t[j] = k;
		end
		return (pos < win_cnt) ? t[pos] : 32'd0;
	endfunction

	function automatic logic [FreqW-1:0] hz_q8(logic [31:0] period);
		logic [63:0] q;
		logic [63:0] cap;
		cap = 64'(MaxHz) << FractionBitsDef;
		if (period == 0) return '0;
		q = (64'(resolution) << FractionBitsDef) / 64'(period);
		if (q > cap) q = cap;
		return q[FreqW-1:0];
	endfunction

	function automatic void take_edge(logic [31:0] ts, logic rise);
		logic [31:0] p, hi_t, lo_t;
		if (!mode_r) begin
			if (!rise) return;
			if (ref_ok) begin
				p = ts - ref_rise;
				if (p < min_per) return; // spike, keep reference
				if (p <= max_per) begin
					store_period(p);
					ms_idle = '0;
				end
			end
			ref_rise = ts;
			ref_ok = 1'b1;
		end else begin
			ms_idle = '0;
			if (pat_fill < 2) begin
				pat_ts[pat_fill] = ts;
				pat_rise[pat_fill] = rise;
				pat_fill++;
				return;
			end
			if (pat_rise[0] && !pat_rise[1] && rise) begin
				hi_t = pat_ts[1] - pat_ts[0];
				lo_t = ts - pat_ts[1];
				p = ts - pat_ts[0];
				if (hi_t >= min_pul && lo_t >= min_pul && p > 0 && p >= min_per) begin
					store_period(p);
					held = hz_q8(period_rank(win_cnt - 1 - win_cnt / 2));
				end
			end
			pat_ts[0] = pat_ts[1];
			pat_rise[0] = pat_rise[1];
			pat_ts[1] = ts;
			pat_rise[1] = rise;
		end
	endfunction

	function automatic reading_t take_read();
		reading_t r;
		logic [31:0] med;
		r.timed_out = 1'b0;
		if (ms_idle > timeout_r) begin
			if (win_cnt != 0 || held != 0) clear_meter();
			r.freq = '0;
			r.timed_out = 1'b1;
		end else if (resolution == 0) begin
			r.freq = held;
		end else if (!mode_r) begin
			if (win_cnt == 0) r.freq = '0;
			else begin
				med = period_rank(win_cnt / 2);
				r.freq = (med == 0) ? held : hz_q8(med);
			end
		end else begin
			pat_fill = 0;
			r.freq = held;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reading_t got, want;
		if (!arst_n) begin
			resolution = 32'd80000000;
			min_per = 32'd4000;
			max_per = 32'd16000000;
			min_pul = 32'd8000;
			timeout_r = 16'd500;
			mode_r = 1'b0;
			clear_meter();
			readings_due.delete();
			errors = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got.freq = out_ch.frequency_q8;
				got.timed_out = out_ch.timed_out;
				if (readings_due.size() == 0) begin
					$display("%t: unexpected word freq=%0d timed_out=%0b", $time,
						got.freq, got.timed_out);
					errors++;
				end else begin
					want = readings_due.pop_front();
					if (got.freq !== want.freq) begin
						$display("%t: frequency_q8 expected %0d actual %0d", $time,
							want.freq, got.freq);
						errors++;
					end
					if (got.timed_out !== want.timed_out) begin
						$display("%t: timed_out expected %0b actual %0b", $time,
							want.timed_out, got.timed_out);
						errors++;
					end
				end
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_MODE: begin
						mode_r = cfg_ch.data[0];
						clear_meter();
					end
					REG_RES: resolution = cfg_ch.data;
					REG_MINP: min_per = cfg_ch.data;
					REG_MAXP: max_per = cfg_ch.data;
					REG_MINPULSE: min_pul = cfg_ch.data;
					REG_TIMEOUT: timeout_r = cfg_ch.data[15:0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready) begin
				case (in_ch.command)
					CMD_EDGE: take_edge(in_ch.timestamp, in_ch.rising);
					CMD_TICK: if (ms_idle != 16'hFFFF) ms_idle++;
					CMD_READ: readings_due.push_back(take_read());
					default: ;
				endcase
			end
		end
	end
endmodule

// ===== tb/tb_edge_capture_frequency_meter_unit.sv =====
`timescale 1ns / 100ps
module tb_edge_capture_frequency_meter_unit;
	import ecfm_pkg::*;

	localparam logic [1:0] CMD_NONE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int errors, pending;
	int idle_pct = 0;
	int stall_pct = 0;
	logic [31:0] tnow = '0;

	logic cur_mode;
	logic [31:0] cur_minp, cur_maxp, cur_pulse;

	ecfm_in_if in_ch();
	ecfm_out_if out_ch();
	ecfm_cfg_if cfg_ch();

	edge_capture_frequency_meter_unit uut (
		.clk(clk), .arst_n(arst_n), .in(in_ch), .out(out_ch), .cfg(cfg_ch)
	);

	ecfm_checker chk (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
		.errors(errors), .pending(pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk) out_ch.ready <= ($urandom % 100) >= stall_pct;

	task automatic send(logic [1:0] cmd, logic [31:0] ts, logic rise);
		if (idle_pct > 0 && ($urandom % 100) < idle_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= cmd;
		in_ch.timestamp <= ts;
		in_ch.rising <= rise;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// edges give no word, so leave room for one full median read to drain
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic setup(logic m, logic [31:0] res, logic [31:0] mnp, logic [31:0] mxp,
		logic [31:0] pul, logic [15:0] tmo);
		write_reg(REG_RES, res);
		write_reg(REG_MINP, mnp);
		write_reg(REG_MAXP, mxp);
		write_reg(REG_MINPULSE, pul);
		write_reg(REG_TIMEOUT, {16'd0, tmo});
		write_reg(REG_MODE, {31'd0, m});
		cur_mode = m;
		cur_minp = mnp;
		cur_maxp = mxp;
		cur_pulse = pul;
	endtask

	function automatic logic [31:0] pick_gap(logic [31:0] lo, logic [31:0] hi);
		int r;
		logic [63:0] top;
		r = $urandom % 10;
		top = 64'(lo) + 60000;
		if (top > 64'(hi)) top = 64'(hi);
		if (r < 7 && hi >= lo) return $urandom_range(top[31:0], lo);
		if (r == 7 && lo > 0) return $urandom_range(lo - 1, 0);
		if (r == 8 && hi < 32'hFFFF_0000) return hi + 1 + ($urandom % 5000);
		return $urandom;
	endfunction

	task automatic random_run(int n);
		int r;
		logic rise_next;
		rise_next = 1'b1;
		for (int i = 0; i < n; i++) begin
			r = $urandom % 100;
			if (r < 70) begin
				if (!cur_mode) begin
					tnow += pick_gap(cur_minp, cur_maxp);
					send(CMD_EDGE, tnow, ($urandom % 8) != 0);
				end else begin
					// mostly a clean alternating pattern, some broken ones
					tnow += (($urandom % 6) == 0) ? $urandom_range(cur_pulse, 0)
						: cur_pulse + ($urandom % 30000);
					if (($urandom % 10) == 0) rise_next = 1'($urandom);
					send(CMD_EDGE, tnow, rise_next);
					rise_next = ~rise_next;
				end
			end else if (r < 82) send(CMD_TICK, $urandom, 1'($urandom));
			else if (r < 97) send(CMD_READ, $urandom, 1'($urandom));
			else send(CMD_NONE, $urandom, 1'($urandom));
		end
		drain();
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.command = CMD_TICK;
		in_ch.timestamp = '0;
		in_ch.rising = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_MODE;
		cfg_ch.data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values in force: empty window, extremes, unknown command
		cur_mode = 1'b0;
		cur_minp = 32'd4000;
		cur_maxp = 32'd16000000;
		cur_pulse = 32'd8000;
		send(CMD_READ, '0, 1'b0);
		send(CMD_EDGE, 32'hFFFF_FFFF, 1'b1);
		send(CMD_EDGE, 32'd3999, 1'b1);
		send(CMD_EDGE, 32'd3998, 1'b1);
		send(CMD_EDGE, 32'd12000, 1'b0);
		send(CMD_EDGE, 32'd7998, 1'b1);
		send(CMD_READ, '0, 1'b1);
		send(CMD_EDGE, 32'd16007998, 1'b1);
		send(CMD_EDGE, 32'd40007999, 1'b1);
		send(CMD_READ, 32'hFFFF_FFFF, 1'b0);
		send(CMD_NONE, 32'hFFFF_FFFF, 1'b1);
		send(CMD_TICK, '0, 1'b0);
		send(CMD_READ, '0, 1'b0);
		drain();
		random_run(150);

		setup(1'b0, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd0, 16'd0);
		stall_pct = 50;
		send(CMD_EDGE, 32'd5, 1'b1);
		send(CMD_EDGE, 32'd5, 1'b1);
		send(CMD_READ, '0, 1'b0);
		send(CMD_TICK, '0, 1'b0);
		send(CMD_READ, '0, 1'b0);
		random_run(150);

		setup(1'b0, 32'hFFFF_FFFF, 32'd100, 32'd1000, 32'd5, 16'd3);
		idle_pct = 50;
		stall_pct = 0;
		random_run(170);

		setup(1'b1, 32'd80000000, 32'd4000, 32'd16000000, 32'd8000, 16'd65535);
		idle_pct = 7;
		stall_pct = 7;
		random_run(180);

		setup(1'b1, 32'd1000000, 32'd0, 32'd0, 32'd0, 16'd5);
		idle_pct = 0;
		stall_pct = 50;
		send(CMD_EDGE, 32'd10, 1'b1);
		send(CMD_EDGE, 32'd10, 1'b0);
		send(CMD_EDGE, 32'd10, 1'b1);
		send(CMD_READ, '0, 1'b0);
		random_run(170);

		setup(1'b0, 32'd0, 32'd50, 32'd200000, 32'd100, 16'd20);
		idle_pct = 50;
		stall_pct = 50;
		random_run(120);

		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
